FILE: sv/wav_riff_stream_parser_macros.svh
// Assertion macros used by the result queue module.
// Each macro takes a label, the clock, the reset and an antecedent and a consequent.
`ifndef WAV_RIFF_STREAM_PARSER_MACROS_SVH
`define WAV_RIFF_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define WRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wav_riff_stream_parser: assertion failed");

// Next-cycle implication, disabled during reset.
`define WRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wav_riff_stream_parser: assertion failed");

`else

`define WRP_ASSERT_NOW(label, clk, rst, ante, cons)
`define WRP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/wrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wrp_pkg;

   // Chunk and header tags, first byte in the most significant position.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] HEADER_BYTES  = 32'd12;
   localparam logic [31:0] CHDR_BYTES    = 32'd8;
   localparam logic [31:0] FMT_MIN_BYTES = 32'd16;

   localparam logic [15:0] FORMAT_PCM = 16'd1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Default depth of the result queue; must be at least two.
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CHDR   = 3'd1,
      PH_FMT    = 3'd2,
      PH_DATA   = 3'd3,
      PH_SKIP   = 3'd4,
      PH_PAD    = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  sample_byte;
      logic        run_start;
      logic        ok;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] sample_bits;
      logic        final_res;
   } rsp_type;

   // Results produced by one byte: count is 0, 1 or 2, in order first, second.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

FILE: sv/wrp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module wrp_parse_core
   import wrp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   input  wire logic     room,
   output push_type      push
);

   logic      in_valid_ff, in_valid_in;
   req_type   in_ff;
   logic      accept, consume;

   phase_type   phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        seen_fmt_ff, seen_fmt_in;
   logic        seen_data_ff, seen_data_in;
   logic        failed_ff, failed_in;

   // The input register holds one byte until the result queue can take
   // everything that byte may produce.
   assign consume   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         cnt_ff       <= '0;
         tag_ff       <= '0;
         len_ff       <= '0;
         fmt_tag_ff   <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         seen_fmt_ff  <= 1'b0;
         seen_data_ff <= 1'b0;
         failed_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         fmt_tag_ff   <= fmt_tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         seen_fmt_ff  <= seen_fmt_in;
         seen_data_ff <= seen_data_in;
         failed_ff    <= failed_in;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [31:0] cnt_inc;
      logic        finish;
      logic        next_chunk;
      logic        ok;

      b          = in_ff.data_byte;
      cnt_inc    = cnt_ff + 32'd1;
      finish     = 1'b0;
      next_chunk = 1'b0;
      ok         = 1'b0;

      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      fmt_tag_in   = fmt_tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      seen_fmt_in  = seen_fmt_ff;
      seen_data_in = seen_data_ff;
      failed_in    = failed_ff;
      push         = '0;

      if (consume) begin
         unique case (phase_ff)
            PH_HEADER: begin
               tag_in = {tag_ff[23:0], b};
               if (cnt_ff == 32'd3 && tag_in != TAG_RIFF) begin
                  failed_in = 1'b1;
               end
               if (cnt_ff == 32'd11 && tag_in != TAG_WAVE) begin
                  failed_in = 1'b1;
               end
               cnt_in = cnt_inc;
               if (cnt_inc == HEADER_BYTES) begin
                  cnt_in   = '0;
                  phase_in = failed_in ? PH_DONE : PH_CHDR;
               end
            end
            PH_CHDR: begin
               if (cnt_ff == 32'd0) begin
                  len_in = '0;
               end
               if (cnt_ff < 32'd4) begin
                  tag_in = {tag_ff[23:0], b};
               end else begin
                  // Length arrives little-endian in header bytes four to seven.
                  case (cnt_ff[1:0])
                     2'd0:    len_in[7:0]   = len_in[7:0] | b;
                     2'd1:    len_in[15:8]  = len_in[15:8] | b;
                     2'd2:    len_in[23:16] = len_in[23:16] | b;
                     default: len_in[31:24] = len_in[31:24] | b;
                  endcase
               end
               cnt_in = cnt_inc;
               if (cnt_inc == CHDR_BYTES) begin
                  cnt_in = '0;
                  if (tag_in == TAG_FMT) begin
                     if (len_in < FMT_MIN_BYTES) begin
                        failed_in = 1'b1;
                        phase_in  = PH_SKIP;
                     end else begin
                        seen_fmt_in = 1'b0;
                        phase_in    = PH_FMT;
                     end
                  end else if (tag_in == TAG_DATA) begin
                     seen_data_in = 1'b1;
                     phase_in     = PH_DATA;
                  end else begin
                     phase_in = PH_SKIP;
                  end
                  if (len_in == 32'd0) begin
                     finish = 1'b1;
                  end
               end
            end
            PH_FMT: begin
               if (cnt_ff < FMT_MIN_BYTES) begin
                  case (cnt_ff[3:0])
                     4'd0:    fmt_tag_in = {8'd0, b};
                     4'd1:    fmt_tag_in = fmt_tag_ff | {b, 8'd0};
                     4'd2:    chan_in = {8'd0, b};
                     4'd3:    chan_in = chan_ff | {b, 8'd0};
                     4'd4:    rate_in = {24'd0, b};
                     4'd5:    rate_in = rate_ff | {16'd0, b, 8'd0};
                     4'd6:    rate_in = rate_ff | {8'd0, b, 16'd0};
                     4'd7:    rate_in = rate_ff | {b, 24'd0};
                     4'd14:   bits_in = {8'd0, b};
                     4'd15:   bits_in = bits_ff | {b, 8'd0};
                     default: ;
                  endcase
               end
               cnt_in = cnt_inc;
               if (cnt_inc == FMT_MIN_BYTES) begin
                  seen_fmt_in = 1'b1;
               end
               finish = (cnt_inc == len_ff);
            end
            PH_DATA: begin
               push.count             = 2'd1;
               push.first.kind        = KIND_SAMPLE;
               push.first.sample_byte = b;
               push.first.run_start   = (cnt_ff == 32'd0);
               cnt_in                 = cnt_inc;
               finish                 = (cnt_inc == len_ff);
            end
            PH_SKIP: begin
               cnt_in = cnt_inc;
               finish = (cnt_inc == len_ff);
            end
            PH_PAD: begin
               next_chunk = 1'b1;
            end
            PH_DONE: ;
            default: ;
         endcase

         if (finish) begin
            cnt_in = '0;
            if (len_in[0]) begin
               phase_in = PH_PAD;
            end else begin
               next_chunk = 1'b1;
            end
         end
         if (next_chunk) begin
            cnt_in   = '0;
            phase_in = (seen_fmt_in && seen_data_in) ? PH_DONE : PH_CHDR;
         end

         if (in_ff.end_of_file) begin
            ok = (phase_in != PH_HEADER) && !failed_in && seen_fmt_in &&
                 (fmt_tag_in == FORMAT_PCM);
            if (push.count == 2'd0) begin
               push.count                = 2'd1;
               push.first.kind           = KIND_STATUS;
               push.first.ok             = ok;
               push.first.channel_count  = ok ? chan_in : 16'd0;
               push.first.sample_rate    = ok ? rate_in : 32'd0;
               push.first.sample_bits    = ok ? bits_in : 16'd0;
               push.first.final_res      = 1'b1;
            end else begin
               push.count                = 2'd2;
               push.second.kind          = KIND_STATUS;
               push.second.ok            = ok;
               push.second.channel_count = ok ? chan_in : 16'd0;
               push.second.sample_rate   = ok ? rate_in : 32'd0;
               push.second.sample_bits   = ok ? bits_in : 16'd0;
               push.second.final_res     = 1'b1;
            end
            phase_in     = PH_HEADER;
            cnt_in       = '0;
            tag_in       = '0;
            len_in       = '0;
            fmt_tag_in   = '0;
            chan_in      = '0;
            rate_in      = '0;
            bits_in      = '0;
            seen_fmt_in  = 1'b0;
            seen_data_in = 1'b0;
            failed_in    = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/wrp_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "wav_riff_stream_parser_macros.svh"

module wrp_rsp_queue
   import wrp_pkg::*;
#(
   parameter int DEPTH = RSP_QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   // Room means space for two results even if nothing leaves this cycle.
   assign room        = (count_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   `WRP_ASSERT_NOW(a_no_overflow, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `WRP_ASSERT_NOW(a_push_needs_room, clock, reset, push.count != 2'd0, room)
   `WRP_ASSERT_NEXT(a_pop_only_drains, clock, reset, pop && push.count == 2'd0, count_ff == $past(count_ff) - CNT_W'(1))
   `WRP_ASSERT_NOW(a_status_last, clock, reset, push.count == 2'd2, push.first.kind == KIND_SAMPLE && push.second.final_res)

endmodule

`default_nettype wire

FILE: sv/wav_riff_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// WAV RIFF stream parser. Feed the file one byte per beat on the req_ channel
// and mark its final byte with end_of_file; the block accepts one byte every
// cycle while not stalled, set by a single pass of tag-compare and counter logic
// between its input register and its result queue. Each byte inside a data chunk
// yields one sample beat on the rsp_ channel (run_start flags the first byte of
// each data chunk), and the end_of_file byte yields a status beat carrying ok and,
// when ok, the channel count, sample rate and bits per sample from the fmt chunk.
// When the final byte is itself a sample, its sample beat comes first and the
// status beat second, so that byte yields two beats on the output. A byte's
// result beats pass from the input register into the result queue, which offers
// them in order; a beat leaves at a clock edge where the output is not stalled. The
// input stalls only when the result queue lacks room for two beats, which
// happens only under output backpressure. After the end_of_file byte all
// parsing state returns to its reset values and the next byte begins a new
// file. No clearing pass is needed after reset.

module wav_riff_stream_parser
   import wrp_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Results from the parse step travel to the queue as one group.
   push_type push;
   logic     room;

   // Parse core: input register, chunk walker state and result forming.
   wrp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   // Result queue: takes up to two beats per cycle and hands out one per beat.
   wrp_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_wav_riff_stream_parser.sv
`timescale 1ns / 1ps

import wrp_pkg::*;

// Tracks the parser state byte by byte and keeps the beats that the block
// still owes on its result channel, oldest first.
class wav_beat_tracker;
   phase_type   phase;
   logic [31:0] pos_count;
   logic [31:0] tag_word;
   logic [31:0] chunk_len;
   logic [15:0] fmt_code;
   logic [15:0] chan_held;
   logic [31:0] rate_held;
   logic [15:0] bits_held;
   bit          fmt_seen;
   bit          data_seen;
   bit          failed;
   rsp_type     awaited_beats[$];
   int          errors;

   function new();
      errors = 0;
      clear_state();
   endfunction

   function void clear_state();
      phase     = PH_HEADER;
      pos_count = '0;
      tag_word  = '0;
      chunk_len = '0;
      fmt_code  = '0;
      chan_held = '0;
      rate_held = '0;
      bits_held = '0;
      fmt_seen  = 1'b0;
      data_seen = 1'b0;
      failed    = 1'b0;
   endfunction

   // Parsing stops for the rest of the file once both a complete fmt and a data chunk are in.
   function void start_next_chunk();
      phase     = (fmt_seen && data_seen) ? PH_DONE : PH_CHDR;
      pos_count = '0;
   endfunction

   function void close_chunk();
      pos_count = '0;
      if (chunk_len[0]) begin
         phase = PH_PAD;
      end else begin
         start_next_chunk();
      end
   endfunction

   // Advances the state by one accepted byte and queues the beats it causes.
   function void take_byte(req_type beat);
      logic [7:0]  b;
      logic [31:0] pos;
      rsp_type     r;
      logic        good;
      b   = beat.data_byte;
      pos = pos_count;
      case (phase)
         PH_HEADER: begin
            tag_word = {tag_word[23:0], b};
            if (pos == 32'd3 && tag_word != TAG_RIFF) failed = 1'b1;
            if (pos == 32'd11 && tag_word != TAG_WAVE) failed = 1'b1;
            pos_count = pos + 32'd1;
            if (pos_count == HEADER_BYTES) begin
               pos_count = '0;
               phase     = failed ? PH_DONE : PH_CHDR;
            end
         end
         PH_CHDR: begin
            if (pos == 32'd0) chunk_len = '0;
            if (pos < 32'd4) begin
               tag_word = {tag_word[23:0], b};
            end else begin
               chunk_len = chunk_len | (32'(b) << (8 * pos[1:0]));
            end
            pos_count = pos + 32'd1;
            if (pos_count == CHDR_BYTES) begin
               pos_count = '0;
               if (tag_word == TAG_FMT) begin
                  if (chunk_len < FMT_MIN_BYTES) begin
                     failed = 1'b1;
                     phase  = PH_SKIP;
                  end else begin
                     fmt_seen = 1'b0;
                     phase    = PH_FMT;
                  end
               end else if (tag_word == TAG_DATA) begin
                  data_seen = 1'b1;
                  phase     = PH_DATA;
               end else begin
                  phase = PH_SKIP;
               end
               if (chunk_len == 32'd0) close_chunk();
            end
         end
         PH_FMT: begin
            case (pos)
               32'd0:  fmt_code = {8'h00, b};
               32'd1:  fmt_code[15:8] = b;
               32'd2:  chan_held = {8'h00, b};
               32'd3:  chan_held[15:8] = b;
               32'd4:  rate_held = {24'h000000, b};
               32'd5:  rate_held[15:8] = b;
               32'd6:  rate_held[23:16] = b;
               32'd7:  rate_held[31:24] = b;
               32'd14: bits_held = {8'h00, b};
               32'd15: bits_held[15:8] = b;
               default: ;
            endcase
            pos_count = pos + 32'd1;
            if (pos_count == FMT_MIN_BYTES) fmt_seen = 1'b1;
            if (pos_count == chunk_len) close_chunk();
         end
         PH_DATA: begin
            r             = '0;
            r.kind        = KIND_SAMPLE;
            r.sample_byte = b;
            r.run_start   = (pos == 32'd0);
            awaited_beats.insert(awaited_beats.size(), r);
            pos_count = pos + 32'd1;
            if (pos_count == chunk_len) close_chunk();
         end
         PH_SKIP: begin
            pos_count = pos + 32'd1;
            if (pos_count == chunk_len) close_chunk();
         end
         PH_PAD: begin
            start_next_chunk();
         end
         default: ;
      endcase

      if (beat.end_of_file) begin
         good = (phase != PH_HEADER) && !failed && fmt_seen && (fmt_code == FORMAT_PCM);
         r           = '0;
         r.kind      = KIND_STATUS;
         r.ok        = good;
         r.final_res = 1'b1;
         if (good) begin
            r.channel_count = chan_held;
            r.sample_rate   = rate_held;
            r.sample_bits   = bits_held;
         end
         awaited_beats.insert(awaited_beats.size(), r);
         clear_state();
      end
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: field %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void match_beat(rsp_type got);
      rsp_type want;
      if (awaited_beats.size() == 0) begin
         $display("%0t: result beat with nothing expected, got %0h", $time, got);
         errors++;
         return;
      end
      want = awaited_beats.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("sample_byte", want.sample_byte, got.sample_byte);
      compare_field("run_start", want.run_start, got.run_start);
      compare_field("ok", want.ok, got.ok);
      compare_field("channel_count", want.channel_count, got.channel_count);
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
      compare_field("sample_bits", want.sample_bits, got.sample_bits);
      compare_field("final_res", want.final_res, got.final_res);
   endfunction
endclass

module tb_wav_riff_stream_parser;

   // The run feeds whole files built from chunk helpers below. Stimulus stops
   // once about this many bytes that the parser actually looks at have gone in.
   localparam int BYTE_TARGET = 1700;
   // Cycles without any accepted beat on either channel before giving up.
   localparam int QUIET_LIMIT = 4000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   wav_beat_tracker tracker;

   // Bytes of the file under construction, first byte at the front.
   logic [7:0] wav_bytes[$];
   // Trailing bytes of that file that the parser is known to ignore.
   int         junk_tail = 0;
   int         fed_bytes = 0;
   // While set, neither side idles, which gives a stretch at full rate.
   bit         steady = 1'b0;
   int         quiet_cycles = 0;

   wav_riff_stream_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The receiver stalls in about 15 percent of cycles, outside the steady
   // stretch. Stall is drawn every cycle, so it lands on every phase of a file.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 15);
   end

   // Both channels are watched at the same edge. An input beat is noted before
   // a result beat is checked, so the order never depends on the latency.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_byte(req_data);
         if (rsp_valid && !rsp_stall) tracker.match_beat(rsp_data);
      end
   end

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Tags go out first byte first, as they appear in the file.
   function automatic void put_tag(logic [31:0] tag);
      for (int i = 3; i >= 0; i--) wav_bytes.insert(wav_bytes.size(), tag[8*i +: 8]);
   endfunction

   // Numeric fields are little-endian.
   function automatic void put_le(logic [31:0] value, int count);
      for (int i = 0; i < count; i++) wav_bytes.insert(wav_bytes.size(), value[8*i +: 8]);
   endfunction

   function automatic void put_body(int count);
      for (int i = 0; i < count; i++) wav_bytes.insert(wav_bytes.size(), 8'($urandom));
   endfunction

   function automatic void trim_to(int count);
      while (wav_bytes.size() > count) void'(wav_bytes.pop_back());
   endfunction

   // A damaged tag has one random bit flipped, which is enough to fail it.
   function automatic void put_header(bit bad_riff, bit bad_wave);
      put_tag(bad_riff ? TAG_RIFF ^ (32'h1 << $urandom_range(31)) : TAG_RIFF);
      put_le($urandom, 4);
      put_tag(bad_wave ? TAG_WAVE ^ (32'h1 << $urandom_range(31)) : TAG_WAVE);
   endfunction

   // A declared length under 16 gets random body bytes instead of fields.
   // Anything past the 16 field bytes is random extension data.
   function automatic void put_fmt(int len, logic [15:0] code, logic [15:0] chans,
                                   logic [31:0] rate, logic [15:0] bits);
      put_tag(TAG_FMT);
      put_le(len, 4);
      if (len >= 16) begin
         put_le(32'(code), 2);
         put_le(32'(chans), 2);
         put_le(rate, 4);
         put_le($urandom, 4);
         put_le($urandom, 2);
         put_le(32'(bits), 2);
         put_body(len - 16);
      end else begin
         put_body(len);
      end
      if (len % 2) put_body(1);
   endfunction

   function automatic void put_data(int len);
      put_tag(TAG_DATA);
      put_le(len, 4);
      put_body(len);
      if (len % 2) put_body(1);
   endfunction

   function automatic void put_other(int len);
      put_tag($urandom);
      put_le(len, 4);
      put_body(len);
      if (len % 2) put_body(1);
   endfunction

   function automatic void put_random_fmt();
      int roll;
      int len;
      roll = $urandom_range(99);
      if (roll < 70) begin
         len = 16;
      end else if (roll < 85) begin
         len = 16 + $urandom_range(1, 8);
      end else begin
         len = $urandom_range(0, 15);
      end
      put_fmt(len, ($urandom_range(99) < 85) ? FORMAT_PCM : 16'($urandom),
              16'($urandom), $urandom, 16'($urandom));
   endfunction

   function automatic void put_random_data();
      put_data($urandom_range(0, 32));
   endfunction

   // Most files are well formed with random contents: optional unknown chunks
   // around one fmt and one data chunk. The rest are shuffled chunk runs, files
   // with damaged tags, pure noise, data whose length overruns the file, junk
   // after the end of parsing, and files cut off at a random point.
   function automatic void build_random_file();
      int roll;
      int pieces;
      bit bad_riff;
      bit bad_wave;
      roll = $urandom_range(99);
      if (roll < 8) begin
         put_body($urandom_range(1, 24));
         return;
      end
      bad_riff = ($urandom_range(99) < 5);
      bad_wave = ($urandom_range(99) < 5);
      put_header(bad_riff, bad_wave);
      if (roll < 60) begin
         if ($urandom_range(1)) put_other($urandom_range(0, 9));
         put_random_fmt();
         if ($urandom_range(3) == 0) put_other($urandom_range(0, 9));
         put_random_data();
      end else begin
         pieces = $urandom_range(1, 5);
         repeat (pieces) begin
            case ($urandom_range(2))
               0: put_random_fmt();
               1: put_random_data();
               default: put_other($urandom_range(0, 9));
            endcase
         end
      end
      if ($urandom_range(99) < 5) begin
         put_tag(TAG_DATA);
         put_le($urandom | 32'h0000_1000, 4);
         put_body($urandom_range(0, 16));
      end else if ($urandom_range(99) < 20) begin
         junk_tail = $urandom_range(1, 6);
         put_body(junk_tail);
      end
      if ($urandom_range(99) < 15) begin
         trim_to($urandom_range(1, wav_bytes.size()));
         junk_tail = 0;
      end
      // Past a failed header the parser ignores everything.
      if ((bad_riff || bad_wave) && wav_bytes.size() > HEADER_BYTES) begin
         junk_tail = wav_bytes.size() - HEADER_BYTES;
      end
   endfunction

   // Offers one beat, idling first at random. Valid is only raised here and only
   // lowered when idle or after the run, so it never gets two assignments in one step.
   task automatic send_beat(input req_type beat);
      while (!steady && ($urandom_range(99) < 15)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sends the file under construction with end_of_file on its last byte.
   task automatic send_file();
      req_type beat;
      for (int i = 0; i < wav_bytes.size(); i++) begin
         beat.data_byte   = wav_bytes[i];
         beat.end_of_file = (i == wav_bytes.size() - 1);
         send_beat(beat);
      end
      fed_bytes += wav_bytes.size() - junk_tail;
      junk_tail = 0;
      wav_bytes.delete();
   endtask

   task automatic run_directed();
      // A file that ends on its very first byte, still inside the header.
      put_body(1);
      send_file();

      // Clean PCM file with extreme format values. The last byte is a sample,
      // so it yields a sample beat followed by the status beat.
      put_header(1'b0, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      put_tag(TAG_DATA);
      put_le(32'd4, 4);
      put_le(32'h7F80_FF00, 4);
      send_file();

      // Damaged RIFF tag, then damaged WAVE tag.
      put_header(1'b1, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
      put_data(2);
      send_file();
      put_header(1'b0, 1'b1);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
      put_data(2);
      send_file();

      // An fmt chunk that declares fewer than 16 bytes is an error.
      put_header(1'b0, 1'b0);
      put_fmt(14, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
      put_data(2);
      send_file();

      // Complete fmt but not integer PCM.
      put_header(1'b0, 1'b0);
      put_fmt(16, 16'd3, 16'd2, 32'd48000, 16'd32);
      put_data(1);
      send_file();

      // Empty and odd unknown chunks, an odd fmt with extension bytes and a
      // pad, an empty data chunk, then bytes after parsing has stopped.
      put_header(1'b0, 1'b0);
      put_other(5);
      put_other(0);
      put_fmt(17, FORMAT_PCM, 16'd1, 32'd22050, 16'd8);
      put_data(0);
      put_body(3);
      send_file();

      // Two data runs before fmt; the data chunk after fmt is never parsed.
      put_header(1'b0, 1'b0);
      put_data(2);
      put_data(3);
      put_fmt(16, FORMAT_PCM, 16'd6, 32'd96000, 16'd24);
      put_data(2);
      send_file();

      // A complete fmt followed by a second fmt cut off by the end of file.
      put_header(1'b0, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
      put_fmt(16, FORMAT_PCM, 16'd1, 32'd11025, 16'd8);
      trim_to(wav_bytes.size() - 10);
      send_file();

      // A later complete fmt overwrites the held format values.
      put_header(1'b0, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
      put_fmt(16, FORMAT_PCM, 16'h8001, 32'h8000_0001, 16'h8001);
      put_data(1);
      send_file();

      // A chunk header cut short, then a data chunk cut short.
      put_header(1'b0, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'd1, 32'd16000, 16'd16);
      put_tag(TAG_DATA);
      put_body(1);
      send_file();
      put_header(1'b0, 1'b0);
      put_fmt(16, FORMAT_PCM, 16'd1, 32'd16000, 16'd16);
      put_tag(TAG_DATA);
      put_le(32'd10, 4);
      put_body(4);
      send_file();
   endtask

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random files until the byte target is met, with a full-rate stretch in
      // the middle of the run.
      while (fed_bytes < BYTE_TARGET) begin
         steady = (fed_bytes >= 700) && (fed_bytes < 1100);
         build_random_file();
         send_file();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Drain: the watchdog catches a result channel that never empties.
      while (tracker.awaited_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/wrp_pkg.sv
sv/wrp_parse_core.sv
sv/wrp_rsp_queue.sv
sv/wav_riff_stream_parser.sv
tb/sv/tb_wav_riff_stream_parser.sv
